// ===== design/ppr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppr_pkg: shared constants for the parabola point rasterizer
// Coordinate width, register map and internal field widths.
// ----------------------------------------------------------------------------
package ppr_pkg;

  // width of the pixel coordinate outputs, 8 to 32
  localparam int unsigned CoordBits = 14;

  // configuration register map
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] RegCenterX     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeightBound = 2'd2;

  localparam logic [CfgDataW-1:0] HeightBoundReset = 12'd94;

  // curve walk state widths
  localparam int unsigned OffXW = 8;
  localparam int unsigned OffYW = 13;
  localparam int unsigned DecW  = 20;

  // region one start value of the decision term
  localparam logic signed [DecW-1:0] DecStart = 20'sd1;
  // (2x+1)^2 at x = 2, the only point where region two is entered
  localparam logic signed [DecW-1:0] EnterSq = 20'sd25;

endpackage

// ===== design/parabola_point_rasterizer.sv =====
// ----------------------------------------------------------------------------
// parabola_point_rasterizer: midpoint rasterizer for y = x*x/4
// Walks the curve up from its apex one step per input transfer and returns
// the point and its mirror about the axis, or a single done marker.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------
//  in        in         in_valid_i / in_ready_o   restart_i
//  out       out        out_valid_o / out_ready_i pixel_x_o pixel_y_o
//                                                 pixel_valid_o last_o
//                                                 finished_o
//  cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i cfg_data_i
//
//  A step is done in the cycle its input transfer happens; the result pair
//  sits in one result register and leaves over two output transfers (one for
//  a done marker). The next input is taken in the cycle the last result of
//  the pair leaves. Reset clears the walk state, returns the registers to
//  their reset values and empties the result register. The cfg port is
//  always ready.
// ----------------------------------------------------------------------------
module parabola_point_rasterizer (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              restart_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ppr_pkg::CoordBits-1:0] pixel_x_o,
  output logic signed [ppr_pkg::CoordBits-1:0] pixel_y_o,
  output logic                              pixel_valid_o,
  output logic                              last_o,
  output logic                              finished_o,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ppr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [ppr_pkg::CfgDataW-1:0]      cfg_data_i
);

  typedef struct packed {
    logic done;   // curve complete marker, no point
    logic fin;
    logic [ppr_pkg::CoordBits-1:0] px;
    logic [ppr_pkg::CoordBits-1:0] nx;
    logic [ppr_pkg::CoordBits-1:0] py;
  } result_t;

  // configuration registers
  logic signed [ppr_pkg::CfgDataW-1:0] center_x_q, center_y_q;
  logic [ppr_pkg::CfgDataW-1:0]        height_bound_q;

  // walk state
  logic [ppr_pkg::OffXW-1:0]       off_x_q, off_x_d;
  logic [ppr_pkg::OffYW-1:0]       off_y_q, off_y_d;
  logic                            region2_q, region2_d;
  logic signed [ppr_pkg::DecW-1:0] dec_q, dec_d;

  // result register
  logic    res_pend_q, res_phase_q;
  result_t res_q, res_d;

  logic in_xfer, out_xfer, out_final;

  // effective state after an optional restart
  logic [ppr_pkg::OffXW-1:0]       cur_x;
  logic [ppr_pkg::OffYW-1:0]       cur_y;
  logic                            cur_r2;
  logic signed [ppr_pkg::DecW-1:0] cur_dec;
  logic                            complete;

  logic                            r1_ystep, r2_xstep;
  logic [ppr_pkg::OffYW-1:0]       r1_y;
  logic [ppr_pkg::OffXW-1:0]       r1_x;
  logic [ppr_pkg::OffYW:0]         r1_y_p1;
  logic signed [ppr_pkg::DecW-1:0] r1_dec, r1_enter_dec, r2_dec;

  logic signed [31:0] sum_px, sum_nx, sum_py;

  assign cfg_ready_o = 1'b1;

  assign out_xfer   = res_pend_q & out_ready_i;
  assign out_final  = out_xfer & (res_q.done | res_phase_q);
  assign in_ready_o = ~res_pend_q | out_final;
  assign in_xfer    = in_valid_i & in_ready_o;

  always_comb begin
    cur_x   = restart_i ? '0 : off_x_q;
    cur_y   = restart_i ? '0 : off_y_q;
    cur_r2  = restart_i ? 1'b0 : region2_q;
    cur_dec = restart_i ? ppr_pkg::DecStart : dec_q;

    complete = cur_y > {1'b0, height_bound_q};

    // region one: step x, step y when the midpoint lies below the curve
    r1_ystep = cur_dec[ppr_pkg::DecW-1];
    r1_y     = cur_y + {{(ppr_pkg::OffYW-1){1'b0}}, r1_ystep};
    r1_x     = cur_x + 8'd1;
    r1_dec   = cur_dec + (r1_ystep ? 20'sd4 : 20'sd0)
             - $signed({{(ppr_pkg::DecW-ppr_pkg::OffXW-1){1'b0}}, cur_x, 1'b0})
             - 20'sd3;
    r1_y_p1      = {1'b0, r1_y} + 14'd1;
    r1_enter_dec = $signed({2'b00, r1_y_p1, 4'b0000}) - ppr_pkg::EnterSq;

    // region two: step y, step x while the midpoint stays inside
    r2_xstep = ~cur_dec[ppr_pkg::DecW-1];
    r2_dec   = cur_dec + 20'sd16
             - (r2_xstep ?
                $signed({{(ppr_pkg::DecW-ppr_pkg::OffXW-3){1'b0}}, cur_x, 3'b000}) + 20'sd8
                : 20'sd0);

    if (complete) begin
      off_x_d   = cur_x;
      off_y_d   = cur_y;
      region2_d = cur_r2;
      dec_d     = cur_dec;
    end else if (!cur_r2) begin
      off_x_d   = r1_x;
      off_y_d   = r1_y;
      region2_d = r1_x >= 8'd2;
      dec_d     = (r1_x >= 8'd2) ? r1_enter_dec : r1_dec;
    end else begin
      off_x_d   = cur_x + {{(ppr_pkg::OffXW-1){1'b0}}, r2_xstep};
      off_y_d   = cur_y + 13'd1;
      region2_d = 1'b1;
      dec_d     = r2_dec;
    end

    sum_px = 32'(center_x_q) + $signed({24'b0, cur_x});
    sum_nx = 32'(center_x_q) - $signed({24'b0, cur_x});
    sum_py = 32'(center_y_q) + $signed({19'b0, cur_y});

    res_d.done = complete;
    res_d.fin  = off_y_d > {1'b0, height_bound_q};
    res_d.px   = sum_px[ppr_pkg::CoordBits-1:0];
    res_d.nx   = sum_nx[ppr_pkg::CoordBits-1:0];
    res_d.py   = sum_py[ppr_pkg::CoordBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q     <= '0;
      center_y_q     <= '0;
      height_bound_q <= ppr_pkg::HeightBoundReset;
      off_x_q        <= '0;
      off_y_q        <= '0;
      region2_q      <= 1'b0;
      dec_q          <= ppr_pkg::DecStart;
      res_pend_q     <= 1'b0;
      res_phase_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ppr_pkg::RegCenterX:     center_x_q     <= cfg_data_i;
          ppr_pkg::RegCenterY:     center_y_q     <= cfg_data_i;
          ppr_pkg::RegHeightBound: height_bound_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_xfer) begin
        off_x_q     <= off_x_d;
        off_y_q     <= off_y_d;
        region2_q   <= region2_d;
        dec_q       <= dec_d;
        res_pend_q  <= 1'b1;
        res_phase_q <= 1'b0;
      end else if (out_final) begin
        res_pend_q  <= 1'b0;
      end else if (out_xfer) begin
        // right point gone, left point next
        res_phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = res_pend_q;
  assign pixel_x_o     = res_q.done ? '0 : (res_phase_q ? res_q.nx : res_q.px);
  assign pixel_y_o     = res_q.done ? '0 : res_q.py;
  assign pixel_valid_o = ~res_q.done;
  assign last_o        = res_q.done | res_phase_q;
  assign finished_o    = res_q.done | res_q.fin;

endmodule
